// File: rtl/bpe_pkg.sv
`default_nettype none

package bpe_pkg;

    // Number of rule registers on the configuration port.
    localparam int RULE_REGS = 6;
    localparam int MAX_RULES_DEF = 6;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes (word addresses).
    localparam logic [2:0] REG_RULE_COUNT = 3'd0;
    localparam logic [2:0] REG_RULE_FIRST = 3'd1;
    localparam logic [2:0] REG_RULE_LAST  = 3'd6;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_data;
    } bpe_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_last;
    } bpe_out_t;

    typedef logic [23:0] rule_t;

    function automatic logic [7:0] rule_key(input rule_t r);
        rule_key = r[23:16];
    endfunction

    function automatic logic [7:0] rule_first(input rule_t r);
        rule_first = r[15:8];
    endfunction

    function automatic logic [7:0] rule_second(input rule_t r);
        rule_second = r[7:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/byte_pair_expander_top.sv
`default_nettype none

// Byte pair expander. Each request carries one compressed byte; it is run through
// the first rule_count substitution rules in order (at most MAX_RULES), and the
// expanded bytes leave one per result request, with run_last on the final byte of
// each expansion and stream_last on the final byte of a request with end_of_data.
// The expansion is walked depth first: pending second pair bytes go onto a stack
// memory of MAX_RULES entries with a registered read. Each step either applies
// one rule or emits one byte, with a stack read state between emitted bytes, and
// stalls on the result side hold emission; a new request is accepted only once
// the last byte of the previous one has been emitted. Rules must be written over
// the APB port only while the block is idle; the block itself does not enforce this.
module byte_pair_expander_top
    import bpe_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire bpe_in_t            s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output bpe_out_t                m_data
);

    localparam int LW  = $clog2(MAX_RULES + 1);
    localparam int SPW = $clog2(MAX_RULES + 1);
    localparam int AW  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int EW  = 8 + LW;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXPAND = 2'd1;
    localparam logic [1:0] ST_POP    = 2'd2;

    // Configuration registers.
    logic [2:0] rule_count_reg;
    rule_t      rules_reg [RULE_REGS];
    logic [2:0] cfg_idx;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_count_reg <= 3'd0;
            for (int i = 0; i < RULE_REGS; i++) begin
                rules_reg[i] <= '0;
            end
        end else if (cfg_wr) begin
            if (cfg_idx == REG_RULE_COUNT) begin
                rule_count_reg <= pwdata[2:0];
            end
            for (int i = 0; i < RULE_REGS; i++) begin
                if (cfg_idx == REG_RULE_FIRST + 3'(i)) begin
                    rules_reg[i] <= pwdata[23:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_idx == REG_RULE_COUNT) begin
            prdata = {29'd0, rule_count_reg};
        end else if (cfg_idx >= REG_RULE_FIRST && cfg_idx <= REG_RULE_LAST) begin
            prdata = {8'd0, rules_reg[cfg_idx - REG_RULE_FIRST]};
        end
    end

    // Expansion control.
    logic [1:0]     state_reg, state_next;
    logic [7:0]     cur_byte_reg, cur_byte_next;
    logic [LW-1:0]  cur_level_reg, cur_level_next;
    logic           eod_reg, eod_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic           m_valid_reg, m_valid_next;
    bpe_out_t       m_data_reg, m_data_next;

    logic [2:0]     active_n;
    logic           hit;
    logic [LW-1:0]  hit_idx;
    rule_t          hit_rule;
    logic           out_free;
    logic           push_en, pop_en;
    logic [EW-1:0]  push_entry;
    logic [SPW-1:0] pop_ptr;

    logic [EW-1:0]  stack_mem [MAX_RULES];
    logic [EW-1:0]  stack_rdata_reg;

    assign active_n = (rule_count_reg > 3'(MAX_RULES)) ? 3'(MAX_RULES) : rule_count_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign pop_ptr  = sp_reg - SPW'(1);

    // The first active rule at or after the current level whose key matches.
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int r = MAX_RULES - 1; r >= 0; r--) begin
            if (3'(r) < active_n && LW'(r) >= cur_level_reg &&
                rule_key(rules_reg[r]) == cur_byte_reg) begin
                hit     = 1'b1;
                hit_idx = LW'(r);
            end
        end
        hit_rule = rules_reg[hit_idx];
    end

    always_comb begin
        state_next     = state_reg;
        cur_byte_next  = cur_byte_reg;
        cur_level_next = cur_level_reg;
        eod_next       = eod_reg;
        sp_next        = sp_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        push_en        = 1'b0;
        pop_en         = 1'b0;
        push_entry     = {rule_second(hit_rule), hit_idx + LW'(1)};

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cur_byte_next  = s_data.in_byte;
                    cur_level_next = '0;
                    eod_next       = s_data.end_of_data;
                    state_next     = ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                if (hit) begin
                    // Keep walking the first pair byte; the second waits on the stack.
                    push_en        = 1'b1;
                    sp_next        = sp_reg + SPW'(1);
                    cur_byte_next  = rule_first(hit_rule);
                    cur_level_next = hit_idx + LW'(1);
                end else if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.out_byte = cur_byte_reg;
                    m_data_next.run_last = (sp_reg == '0);
                    m_data_next.stream_last = (sp_reg == '0) && eod_reg;
                    if (sp_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        pop_en     = 1'b1;
                        sp_next    = pop_ptr;
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP: begin
                cur_byte_next  = stack_rdata_reg[EW-1:LW];
                cur_level_next = stack_rdata_reg[LW-1:0];
                state_next     = ST_EXPAND;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            stack_mem[sp_reg[AW-1:0]] <= push_entry;
        end
        if (pop_en) begin
            stack_rdata_reg <= stack_mem[pop_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_byte_reg  <= cur_byte_next;
        cur_level_reg <= cur_level_next;
        eod_reg       <= eod_next;
        m_data_reg    <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SPW'(MAX_RULES))
        else $error("stack pointer beyond rule depth");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> sp_reg == '0)
        else $error("stack not empty while idle");

    a_accept_expand: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_EXPAND)
        else $error("accepted request did not start expansion");

    a_pop_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_POP |=> state_reg == ST_EXPAND)
        else $error("stack read did not return to expansion");

    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_en |-> sp_reg != '0 && !push_en)
        else $error("pop from empty stack or overlapping push");
`endif

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import bpe_pkg::*;

    // Index past the last rule register; writes there must be dropped.
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    bpe_in_t            s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    bpe_out_t           m_data;

    bpe_in_t  pending_requests[$];
    bpe_out_t expanded_bytes[$];
    bpe_out_t next_expanded;

    logic [2:0] rule_count_q = '0;
    rule_t      rule_tab[RULE_REGS] = '{default: '0};
    logic [7:0] alphabet_base = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    byte_pair_expander_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Runs one request byte through the active rules and queues the bytes it expands to.
    function automatic void expand_request(input bpe_in_t req);
        logic [7:0] cur[$];
        logic [7:0] nxt[$];
        int         n_rules;
        bpe_out_t   item;
        n_rules = (rule_count_q > MAX_RULES_DEF) ? MAX_RULES_DEF : rule_count_q;
        cur.push_back(req.in_byte);
        for (int r = 0; r < n_rules; r++) begin
            nxt.delete();
            // Each rule scans only the bytes it was handed, never its own output.
            foreach (cur[i]) begin
                if (cur[i] == rule_tab[r][23:16]) begin
                    nxt.push_back(rule_tab[r][15:8]);
                    nxt.push_back(rule_tab[r][7:0]);
                end else begin
                    nxt.push_back(cur[i]);
                end
            end
            cur = nxt;
        end
        foreach (cur[k]) begin
            item.out_byte    = cur[k];
            item.run_last    = (k == cur.size() - 1);
            item.stream_last = item.run_last && req.end_of_data;
            expanded_bytes.push_back(item);
        end
    endfunction

    // Request driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expand_request(s_data);
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_requests.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                if (expanded_bytes.size() == 0) begin
                    $error("unexpected result byte %0h", m_data.out_byte);
                    mismatch_count++;
                end else begin
                    next_expanded = expanded_bytes.pop_front();
                    check_field("out_byte", 32'(next_expanded.out_byte),
                                32'(m_data.out_byte));
                    check_field("run_last", 32'(next_expanded.run_last),
                                32'(m_data.run_last));
                    check_field("stream_last", 32'(next_expanded.stream_last),
                                32'(m_data.stream_last));
                end
            end
        end
    end

    task automatic apb_cycle(input logic [2:0] idx, input logic wr, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes a register; for the count and rule registers it also mirrors it locally and reads it back.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        apb_cycle(idx, 1'b1, value);
        if (idx == REG_RULE_COUNT) begin
            rule_count_q = value[2:0];
            apb_cycle(idx, 1'b0, '0);
            check_field("rule_count", 32'(rule_count_q), 32'(prdata[2:0]));
        end else if (idx <= REG_RULE_LAST) begin
            rule_tab[idx - REG_RULE_FIRST] = value[23:0];
            apb_cycle(idx, 1'b0, '0);
            check_field("rule", 32'(rule_tab[idx - REG_RULE_FIRST]), 32'(prdata[23:0]));
        end
    endtask

    task automatic queue_request(input logic [7:0] b, input logic eod);
        pending_requests.push_back(bpe_in_t'{in_byte: b, end_of_data: eod});
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(99) < 80) begin
            return alphabet_base + 8'($urandom_range(3));
        end
        return 8'($urandom);
    endfunction

    task automatic load_random_rules();
        alphabet_base = 8'($urandom);
        write_reg(REG_RULE_COUNT, {29'($urandom), 3'($urandom_range(7))});
        for (int r = 0; r < RULE_REGS; r++) begin
            write_reg(REG_RULE_FIRST + 3'(r),
                      {8'($urandom), pick_byte(), pick_byte(), pick_byte()});
        end
        write_reg(REG_UNMAPPED, $urandom);
    endtask

    // Holds off until every request is taken and every result byte has come back.
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_requests.size() != 0 || s_valid || expanded_bytes.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: every byte passes through untouched.
        queue_request(8'h00, 1'b0);
        queue_request(8'hFF, 1'b1);
        queue_request(8'h5A, 1'b0);
        queue_request(8'hA5, 1'b1);
        wait_idle();

        // All six rules double 0xFF, so it expands to the full 64 bytes.
        write_reg(REG_RULE_COUNT, 32'd6);
        for (int r = 0; r < RULE_REGS; r++) begin
            write_reg(REG_RULE_FIRST + 3'(r), 32'hFFFF_FFFF);
        end
        queue_request(8'hFF, 1'b1);
        queue_request(8'h00, 1'b0);
        queue_request(8'hFF, 1'b0);
        wait_idle();

        // A count of seven behaves as six; the unmapped register is ignored.
        write_reg(REG_RULE_COUNT, 32'hFFFF_FFFF);
        for (int r = 0; r < RULE_REGS; r++) begin
            write_reg(REG_RULE_FIRST + 3'(r), 32'h0000_0000);
        end
        write_reg(REG_UNMAPPED, 32'h00FF_00FF);
        queue_request(8'h00, 1'b1);
        queue_request(8'h01, 1'b0);
        queue_request(8'h80, 1'b1);
        wait_idle();

        // Chained rules, with a key equal to a pair byte and unused rules that must not act.
        write_reg(REG_RULE_COUNT, 32'd3);
        write_reg(REG_RULE_FIRST + 3'd0, 32'h0010_1112);
        write_reg(REG_RULE_FIRST + 3'd1, 32'h0011_1013);
        write_reg(REG_RULE_FIRST + 3'd2, 32'h0012_1212);
        write_reg(REG_RULE_FIRST + 3'd3, 32'h0010_AAAA);
        write_reg(REG_RULE_FIRST + 3'd4, 32'h00FF_FFFF);
        write_reg(REG_RULE_FIRST + 3'd5, 32'h0013_0000);
        queue_request(8'h10, 1'b0);
        queue_request(8'h11, 1'b1);
        queue_request(8'h12, 1'b0);
        queue_request(8'h13, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            for (int half = 0; half < 2; half++) begin
                load_random_rules();
                repeat (44) queue_request(pick_byte(), $urandom_range(3) == 0);
                wait_idle();
            end
        end

        repeat (200) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("tb: FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/bpe_pkg.sv
rtl/byte_pair_expander_top.sv
dv/tb.sv
